// ----- sv/ecfr_pkg.sv -----
// Shared types, codes and defaults for the escaped command frame receiver.
package ecfr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF  = 64;
  localparam int unsigned HANDLER_COUNT_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_SEP        = 3'd0,
    CFG_CMD_SEP          = 3'd1,
    CFG_ESC_CHAR         = 3'd2,
    CFG_ACK_ID           = 3'd3,
    CFG_ATTACHED_MASK    = 3'd4,
    CFG_DEFAULT_ATTACHED = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_STRIP  = 2'd0,
    PH_SPACE  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DISP_NONE     = 2'd0,
    DISP_DEFAULT  = 2'd1,
    DISP_ATTACHED = 2'd2
  } disp_t;

  localparam logic [7:0] FIELD_SEP_RST = 8'd44;
  localparam logic [7:0] CMD_SEP_RST   = 8'd59;
  localparam logic [7:0] ESC_CHAR_RST  = 8'd47;

  typedef struct packed {
    logic [7:0] field_sep;
    logic [7:0] cmd_sep;
    logic [7:0] esc_char;
  } framing_cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  prev_char;
    logic [15:0] accum;
    logic        negative;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{phase: PH_STRIP, prev_char: 8'd0,
                                           accum: 16'd0, negative: 1'b0};

endpackage

// ----- sv/escaped_command_frame_receiver.sv -----
// Top level of the escaped command frame receiver: registers, handshakes and configuration.
// Takes one received byte per request and returns one result per byte; a byte can be
// accepted in every cycle while the result side is not stalled. A byte passes an input
// register, then the framing and first-field parse logic plus the handler lookup, and
// lands in the result register once the output is not stalled.
// The result is all zeros unless the byte was an unescaped command separator ending a
// non-empty message. Configuration writes must be made while no request is in flight.
module escaped_command_frame_receiver #(
  parameter int unsigned BUFFER_BYTES  = ecfr_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned HANDLER_COUNT = ecfr_pkg::HANDLER_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_message_done,
  output logic signed [15:0]              out_command_id,
  output logic                            out_ack_match,
  output logic [1:0]                      out_dispatch,
  output logic [4:0]                      out_handler_slot,
  input  logic                            cfg_we,
  input  logic [ecfr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ecfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ecfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);

  framing_cfg_t     fcfg_r;
  logic [15:0]      ack_id_r;
  logic [31:0]      mask_r;
  logic             dflt_r;

  logic             in_vld_r;
  logic [7:0]       byte_r;
  logic             advance;

  logic [7:0]       sprev_r, sprev_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  parse_state_t     pstate_r, pstate_nxt;

  logic             done;
  logic [15:0]      id;
  logic             ack;
  logic [1:0]       disp;
  logic [4:0]       slot;

  logic             out_vld_r;
  logic             done_r;
  logic [15:0]      id_r;
  logic             ack_r;
  logic [1:0]       disp_r;
  logic [4:0]       slot_r;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  ecfr_frame #(.BUFFER_BYTES(BUFFER_BYTES)) u_frame (
    .rx_byte         (byte_r),
    .fcfg            (fcfg_r),
    .stream_prev     (sprev_r),
    .count           (count_r),
    .pstate          (pstate_r),
    .stream_prev_nxt (sprev_nxt),
    .count_nxt       (count_nxt),
    .pstate_nxt      (pstate_nxt),
    .done            (done),
    .id              (id)
  );

  ecfr_dispatch #(.HANDLER_COUNT(HANDLER_COUNT)) u_dispatch (
    .done             (done),
    .id               (id),
    .ack_id           (ack_id_r),
    .attached_mask    (mask_r),
    .default_attached (dflt_r),
    .ack_match        (ack),
    .dispatch         (disp),
    .handler_slot     (slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcfg_r   <= '{field_sep: FIELD_SEP_RST, cmd_sep: CMD_SEP_RST, esc_char: ESC_CHAR_RST};
      ack_id_r <= 16'd0;
      mask_r   <= 32'd0;
      dflt_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FIELD_SEP:        fcfg_r.field_sep <= cfg_wdata[7:0];
        CFG_CMD_SEP:          fcfg_r.cmd_sep   <= cfg_wdata[7:0];
        CFG_ESC_CHAR:         fcfg_r.esc_char  <= cfg_wdata[7:0];
        CFG_ACK_ID:           ack_id_r         <= cfg_wdata[15:0];
        CFG_ATTACHED_MASK:    mask_r           <= cfg_wdata[31:0];
        CFG_DEFAULT_ATTACHED: dflt_r           <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sprev_r   <= 8'd0;
      count_r   <= '0;
      pstate_r  <= PARSE_CLEAR;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        sprev_r   <= sprev_nxt;
        count_r   <= count_nxt;
        pstate_r  <= pstate_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
    if (advance) begin
      done_r <= done;
      id_r   <= id;
      ack_r  <= ack;
      disp_r <= disp;
      slot_r <= slot;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_message_done = done_r;
  assign out_command_id   = id_r;
  assign out_ack_match    = ack_r;
  assign out_dispatch     = disp_r;
  assign out_handler_slot = slot_r;

endmodule

// ----- sv/ecfr_frame.sv -----
// Per-byte framing, escape tracking and on-the-fly parsing of the first field.
module ecfr_frame #(
  parameter int unsigned BUFFER_BYTES = ecfr_pkg::BUFFER_BYTES_DEF,
  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES)
) (
  input  logic [7:0]             rx_byte,
  input  ecfr_pkg::framing_cfg_t fcfg,
  input  logic [7:0]             stream_prev,
  input  logic [CNT_W-1:0]       count,
  input  ecfr_pkg::parse_state_t pstate,
  output logic [7:0]             stream_prev_nxt,
  output logic [CNT_W-1:0]       count_nxt,
  output ecfr_pkg::parse_state_t pstate_nxt,
  output logic                   done,
  output logic [15:0]            id
);
  import ecfr_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_BYTES - 1);

  logic               s_esc;
  logic               p_esc;
  logic               is_digit;
  logic               is_space;
  logic [CNT_W-1:0]   count_inc;
  logic [15:0]        accum_dig;
  parse_state_t       fed;
  phase_t             ph_eff;
  logic [7:0]         pprev_eff;

  assign is_digit  = (rx_byte >= 8'd48) && (rx_byte <= 8'd57);
  assign is_space  = (rx_byte == 8'd32) || ((rx_byte >= 8'd9) && (rx_byte <= 8'd13));
  assign accum_dig = (pstate.accum << 3) + (pstate.accum << 1) + {12'd0, rx_byte[3:0]};
  assign count_inc = count + CNT_W'(1);
  assign s_esc     = (stream_prev == fcfg.esc_char);

  // Parser update for a stored byte.
  always_comb begin
    fed       = pstate;
    ph_eff    = pstate.phase;
    pprev_eff = pstate.prev_char;
    p_esc     = 1'b0;
    if (pstate.phase != PH_DONE) begin
      if (rx_byte == 8'd0) begin
        fed.phase = PH_DONE;
      end else if (!(pstate.phase == PH_STRIP && fcfg.esc_char != 8'd0 &&
                     rx_byte == fcfg.field_sep)) begin
        if (pstate.phase == PH_STRIP) begin
          ph_eff    = PH_SPACE;
          pprev_eff = 8'd0;
        end
        p_esc         = (pprev_eff == fcfg.esc_char);
        fed.phase     = ph_eff;
        fed.prev_char = (rx_byte == fcfg.esc_char && p_esc) ? 8'd0 : rx_byte;
        if (rx_byte == fcfg.field_sep && !p_esc) begin
          fed.phase = PH_DONE;
        end else if (ph_eff == PH_SPACE) begin
          priority if (is_space) begin
            fed.phase = PH_SPACE;
          end else if (rx_byte == 8'd43) begin
            fed.phase = PH_DIGITS;
          end else if (rx_byte == 8'd45) begin
            fed.phase    = PH_DIGITS;
            fed.negative = 1'b1;
          end else if (!is_digit) begin
            fed.phase = PH_DONE;
          end else begin
            fed.phase = PH_DIGITS;
            fed.accum = accum_dig;
          end
        end else if (!is_digit) begin
          fed.phase = PH_DONE;
        end else begin
          fed.accum = accum_dig;
        end
      end
    end
  end

  // Stream level: escape tracking, message end and overflow.
  always_comb begin
    stream_prev_nxt = (rx_byte == fcfg.esc_char && s_esc) ? 8'd0 : rx_byte;
    count_nxt       = count;
    pstate_nxt      = pstate;
    done            = 1'b0;
    id              = 16'd0;
    if (rx_byte != 8'd0 || s_esc) begin
      if (rx_byte == fcfg.cmd_sep && !s_esc) begin
        if (count != '0) begin
          done            = 1'b1;
          id              = pstate.negative ? (16'd0 - pstate.accum) : pstate.accum;
          stream_prev_nxt = 8'd0;
        end
        count_nxt  = '0;
        pstate_nxt = PARSE_CLEAR;
      end else if (count_inc == CNT_LAST) begin
        count_nxt  = '0;
        pstate_nxt = PARSE_CLEAR;
      end else begin
        count_nxt  = count_inc;
        pstate_nxt = fed;
      end
    end
  end

endmodule

// ----- sv/ecfr_dispatch.sv -----
// Acknowledge compare and handler selection for a completed message.
module ecfr_dispatch #(
  parameter int unsigned HANDLER_COUNT = ecfr_pkg::HANDLER_COUNT_DEF
) (
  input  logic        done,
  input  logic [15:0] id,
  input  logic [15:0] ack_id,
  input  logic [31:0] attached_mask,
  input  logic        default_attached,
  output logic        ack_match,
  output logic [1:0]  dispatch,
  output logic [4:0]  handler_slot
);
  import ecfr_pkg::*;

  localparam logic [15:0] ID_MAX = 16'(HANDLER_COUNT);

  logic [15:0] id_m1;
  logic        in_range;

  assign id_m1     = id - 16'd1;
  assign in_range  = (id >= 16'd1) && (id <= ID_MAX);
  assign ack_match = done && (id == ack_id);

  always_comb begin
    dispatch     = DISP_NONE;
    handler_slot = 5'd0;
    if (done) begin
      if (in_range && attached_mask[id_m1[4:0]]) begin
        dispatch     = DISP_ATTACHED;
        handler_slot = id_m1[4:0];
      end else if (default_attached) begin
        dispatch = DISP_DEFAULT;
      end
    end
  end

endmodule

// ----- verif/ecfr_frame_checker.sv -----
// Checker for the escaped command frame receiver: predicts every result and compares it.
module ecfr_frame_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_message_done,
  input  logic signed [15:0]              out_command_id,
  input  logic                            out_ack_match,
  input  logic [1:0]                      out_dispatch,
  input  logic [4:0]                      out_handler_slot,
  input  logic                            cfg_we,
  input  logic [ecfr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ecfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import ecfr_pkg::*;

  typedef struct packed {
    logic        done;
    logic [15:0] id;
    logic        ack;
    disp_t       disp;
    logic [4:0]  slot;
  } frame_report_t;

  logic [7:0]  field_sep_q;
  logic [7:0]  cmd_sep_q;
  logic [7:0]  esc_q;
  logic [15:0] ack_q;
  logic [31:0] mask_q;
  logic        dflt_q;

  logic [7:0]  prev_stream;
  int unsigned stored;
  phase_t      phase;
  logic [7:0]  prev_parse;
  logic [15:0] accum;
  logic        negative;

  frame_report_t expected_reports[$];
  frame_report_t exp_r;
  frame_report_t got_r;

  function automatic void clear_parse();
    phase      = PH_STRIP;
    prev_parse = 8'd0;
    accum      = 16'd0;
    negative   = 1'b0;
  endfunction

  function automatic void feed_number(input logic [7:0] b);
    logic digit;
    digit = (b >= "0") && (b <= "9");
    if (phase == PH_SPACE) begin
      if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) return;
      if (b == "+") begin
        phase = PH_DIGITS;
        return;
      end
      if (b == "-") begin
        negative = 1'b1;
        phase    = PH_DIGITS;
        return;
      end
      if (!digit) begin
        phase = PH_DONE;
        return;
      end
      phase = PH_DIGITS;
    end else if (!digit) begin
      phase = PH_DONE;
      return;
    end
    accum = accum * 16'd10 + 16'(b - 8'd48);
  endfunction

  function automatic void parse_first_field(input logic [7:0] b);
    logic escaped;
    if (phase == PH_DONE) return;
    if (b == 8'd0) begin
      phase = PH_DONE;
      return;
    end
    if (phase == PH_STRIP) begin
      if (esc_q != 8'd0 && b == field_sep_q) return;
      phase      = PH_SPACE;
      prev_parse = 8'd0;
    end
    escaped    = (prev_parse == esc_q);
    prev_parse = (b == esc_q && escaped) ? 8'd0 : b;
    if (b == field_sep_q && !escaped) begin
      phase = PH_DONE;
      return;
    end
    feed_number(b);
  endfunction

  function automatic frame_report_t take_byte(input logic [7:0] b);
    frame_report_t r;
    logic          escaped;
    logic [15:0]   id;
    r           = '0;
    escaped     = (prev_stream == esc_q);
    prev_stream = (b == esc_q && escaped) ? 8'd0 : b;
    if (b != 8'd0 || escaped) begin
      if (b == cmd_sep_q && !escaped) begin
        if (stored > 0) begin
          id     = negative ? (16'd0 - accum) : accum;
          r.done = 1'b1;
          r.id   = id;
          r.ack  = (id == ack_q);
          if (id >= 16'd1 && id <= HANDLER_COUNT_DEF && id <= 16'd32 &&
              mask_q[5'(id - 16'd1)]) begin
            r.disp = DISP_ATTACHED;
            r.slot = 5'(id - 16'd1);
          end else if (dflt_q) begin
            r.disp = DISP_DEFAULT;
          end
          prev_stream = 8'd0;
        end
        stored = 0;
        clear_parse();
      end else begin
        parse_first_field(b);
        stored++;
        if (stored >= BUFFER_BYTES_DEF - 1) begin
          stored = 0;
          clear_parse();
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      field_sep_q = FIELD_SEP_RST;
      cmd_sep_q   = CMD_SEP_RST;
      esc_q       = ESC_CHAR_RST;
      ack_q       = 16'd0;
      mask_q      = 32'd0;
      dflt_q      = 1'b0;
      prev_stream = 8'd0;
      stored      = 0;
      clear_parse();
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FIELD_SEP:        field_sep_q = cfg_wdata[7:0];
          CFG_CMD_SEP:          cmd_sep_q   = cfg_wdata[7:0];
          CFG_ESC_CHAR:         esc_q       = cfg_wdata[7:0];
          CFG_ACK_ID:           ack_q       = cfg_wdata[15:0];
          CFG_ATTACHED_MASK:    mask_q      = cfg_wdata[31:0];
          CFG_DEFAULT_ATTACHED: dflt_q      = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got_r.done = out_message_done;
        got_r.id   = out_command_id;
        got_r.ack  = out_ack_match;
        got_r.disp = disp_t'(out_dispatch);
        got_r.slot = out_handler_slot;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result at %0t: done=%0b id=%0d ack=%0b disp=%0d slot=%0d",
                     $time, got_r.done, $signed(got_r.id), got_r.ack, got_r.disp, got_r.slot);
        end else begin
          exp_r = expected_reports.pop_front();
          if (got_r !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"Mismatch at %0t: expected done=%0b id=%0d ack=%0b disp=%0d slot=%0d,",
                        " got done=%0b id=%0d ack=%0b disp=%0d slot=%0d"},
                       $time, exp_r.done, $signed(exp_r.id), exp_r.ack, exp_r.disp, exp_r.slot,
                       got_r.done, $signed(got_r.id), got_r.ack, got_r.disp, got_r.slot);
          end
        end
      end
      if (in_valid && in_ready) expected_reports.push_back(take_byte(in_rx_byte));
    end
    pending = expected_reports.size();
  end

endmodule

// ----- verif/escaped_command_frame_receiver_tb.sv -----
// Testbench top for the escaped command frame receiver: stimulus, configuration and verdict.
module escaped_command_frame_receiver_tb;
  import ecfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_rx_byte = 8'd0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic                   out_message_done;
  logic signed [15:0]     out_command_id;
  logic                   out_ack_match;
  logic [1:0]             out_dispatch;
  logic [4:0]             out_handler_slot;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int fail_count;
  int pending;

  logic [7:0]  fsep_m = FIELD_SEP_RST;
  logic [7:0]  csep_m = CMD_SEP_RST;
  logic [7:0]  esc_m  = ESC_CHAR_RST;
  logic [15:0] ack_m  = 16'd0;
  bit          calm   = 1'b0;
  bit          hold_request = 1'b0;
  int          hold_left    = 0;
  int          bytes_sent   = 0;
  int          quiet;

  always #5 clk = ~clk;

  escaped_command_frame_receiver DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_done (out_message_done),
    .out_command_id   (out_command_id),
    .out_ack_match    (out_ack_match),
    .out_dispatch     (out_dispatch),
    .out_handler_slot (out_handler_slot),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  ecfr_frame_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_done (out_message_done),
    .out_command_id   (out_command_id),
    .out_ack_match    (out_ack_match),
    .out_dispatch     (out_dispatch),
    .out_handler_slot (out_handler_slot),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // The result side stalls at random; a requested hold-off keeps it stalled for a long stretch.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      out_ready <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      hold_request = 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic push_literal(input logic [7:0] b);
    if (b == csep_m || b == esc_m || b == 8'd0) push_byte(esc_m);
    push_byte(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_command();
    int         kind;
    int         id;
    logic [7:0] blank;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) push_byte(fsep_m);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
      blank = 8'($urandom_range(9, 14));
      push_byte(blank == 8'd14 ? 8'd32 : blank);
    end
    if (kind == 8) begin
      push_text($sformatf("%0d", $signed(ack_m)));
    end else if (kind == 9) begin
      push_literal(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0: push_byte("+");
        1: push_byte("-");
        default: ;
      endcase
      id = (kind < 6) ? $urandom_range(0, 33) : $urandom_range(0, 99999);
      push_text($sformatf("%0d", id));
    end
    if ($urandom_range(0, 1) == 1) begin
      push_byte(fsep_m);
      repeat ($urandom_range(0, 6)) push_literal(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 24) == 0)
      repeat ($urandom_range(60, 70)) push_literal(8'($urandom_range(0, 255)));
    push_byte(csep_m);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 5))
        0: push_byte(esc_m);
        1: push_byte(8'd0);
        2: push_byte(csep_m);
        3: push_byte(fsep_m);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_traffic(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      if ($urandom_range(0, 99) < 80) push_command();
      else push_noise();
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] fs, input logic [7:0] cs, input logic [7:0] es,
                           input logic [15:0] ack, input logic [31:0] mask,
                           input logic dflt);
    fsep_m = fs;
    csep_m = cs;
    esc_m  = es;
    ack_m  = ack;
    write_reg(CFG_FIELD_SEP, {24'd0, fs});
    write_reg(CFG_CMD_SEP, {24'd0, cs});
    write_reg(CFG_ESC_CHAR, {24'd0, es});
    write_reg(CFG_ACK_ID, {16'd0, ack});
    write_reg(CFG_ATTACHED_MASK, mask);
    write_reg(CFG_DEFAULT_ATTACHED, {31'd0, dflt});
  endtask

  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Dropped zero, empty message, stripped separator with sign, wrap at the most negative id,
    // escaped escape, an escaped zero kept in the message, and the top byte value.
    push_byte(8'd0);
    push_text(";");
    push_text(", +7;");
    push_text("-32768;");
    push_text("//;");
    push_byte("/");
    push_byte(8'd0);
    push_text("9;");
    push_byte(8'hFF);
    push_text(";");
    run_traffic(140);
    drain();

    configure(8'd0, 8'd255, 8'd0, 16'h8000, 32'hFFFF_FFFF, 1'b1);
    run_traffic(150);
    drain();

    configure(8'd255, 8'd0, 8'd255, 16'h7FFF, $urandom, 1'b0);
    run_traffic(80);
    drain();

    calm = 1'b1;
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 16'($urandom_range(0, 40)), $urandom,
              1'($urandom_range(0, 1)));
    run_traffic(150);
    drain();
    calm = 1'b0;

    configure(",", ";", "/", 16'($urandom_range(0, 33)), $urandom, 1'($urandom_range(0, 1)));
    run_traffic(40);
    hold_request = 1'b1;
    run_traffic(120);
    drain();

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
